// ===== src/cfs_pkg.sv =====
// shared types and constants of the case folding substring search
package cfs_pkg;

  // one fold table has one entry per byte value
  localparam int TABLE_SIZE = 'h100;
  // both fold tables share one memory, the table select is the top address bit
  localparam int FOLD_DEPTH = 2 * TABLE_SIZE;
  localparam int FOLD_AW    = $clog2(FOLD_DEPTH);

  typedef enum logic [1:0] {
    CMD_TEXT      = 2'd0,
    CMD_PATTERN   = 2'd1,
    CMD_FULL_FOLD = 2'd2,
    CMD_CASE_FOLD = 2'd3
  } cmd_e;

  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_CASE  = 2'd1;
  localparam logic [1:0] MODE_EXACT = 2'd2;

  localparam int APB_AW = 4;
  localparam logic [1:0] REG_MATCH_MODE     = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] REG_REPORT_ALL     = 2'd2;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0] match_mode;
    logic [6:0] pattern_length;
    logic       report_all;
  } cfg_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] slot;
    logic [7:0] byte_value;
    logic       end_of_text;
  } item_t;

  // text byte leaving the compare stage
  typedef struct packed {
    logic valid;
    logic eot;
  } text_step_t;

  // all results of one text byte
  typedef struct packed {
    logic        has_match;
    logic [31:0] match_pos;
    logic        has_sum;
    logic [31:0] sum_pos;
    logic        sum_found;
  } res_entry_t;

endpackage

// ===== src/cfs_if.sv =====
// item and result channels of the case folding substring search
interface cfs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] slot;
  logic [7:0] byte_value;
  logic       end_of_text;

  modport source (output valid, cmd, slot, byte_value, end_of_text, input ready);
  modport sink (input valid, cmd, slot, byte_value, end_of_text, output ready);
endinterface

interface cfs_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] position;
  logic        found;
  logic        last;

  modport source (output valid, kind, position, found, last, input ready);
  modport sink (input valid, kind, position, found, last, output ready);
endinterface

// ===== src/cfs_regs.sv =====
// apb configuration registers
module cfs_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cfs_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output cfs_pkg::cfg_t             cfg_o,
  output logic                      len_wr_o
);

  cfs_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d    = cfg_q;
    len_wr_o = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        cfs_pkg::REG_MATCH_MODE:     cfg_d.match_mode = pwdata[1:0];
        cfs_pkg::REG_PATTERN_LENGTH: begin
          cfg_d.pattern_length = pwdata[6:0];
          len_wr_o             = 1'b1;
        end
        cfs_pkg::REG_REPORT_ALL:     cfg_d.report_all = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cfs_pkg::REG_MATCH_MODE:     prdata = 32'(cfg_q.match_mode);
      cfs_pkg::REG_PATTERN_LENGTH: prdata = 32'(cfg_q.pattern_length);
      cfs_pkg::REG_REPORT_ALL:     prdata = 32'(cfg_q.report_all);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_mode     <= cfs_pkg::MODE_EXACT;
      cfg_q.pattern_length <= '0;
      cfg_q.report_all     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/cfs_front.sv =====
// fold memory, pattern memory, aligned pattern copy, text window and compare
module cfs_front #(
  parameter int MAX_PATTERN = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        match_mode_i,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]  len_i,
  input  logic                              len_wr_i,
  input  logic                              acc_i,
  input  cfs_pkg::item_t                    item_i,
  output logic                              busy_o,
  output logic                              s1_valid_o,
  output cfs_pkg::text_step_t               step_o,
  output logic [MAX_PATTERN-1:0]            eq_o
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int PW = $clog2(MAX_PATTERN);
  localparam int SW = (LW > 8) ? LW : 8;

  // fold tables, both in one memory
  logic [7:0]                 fold_mem [cfs_pkg::FOLD_DEPTH];
  logic [7:0]                 fold_q;
  logic [cfs_pkg::FOLD_AW-1:0] fold_rd_addr;

  // pattern bytes by slot, and the copy aligned to the window
  logic [7:0] pat_mem [MAX_PATTERN];
  logic [7:0] pat_rd_q;
  logic [7:0] pal_q [MAX_PATTERN];

  logic [7:0] win_q   [MAX_PATTERN];
  logic [7:0] win_new [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_q;

  logic                s1_v_q;
  cfs_pkg::item_t      s1_q;
  cfs_pkg::text_step_t step_q;
  logic [7:0]          folded;
  logic                s1_text, s1_pat;
  logic                pat_in_store, pat_in_len;
  logic [PW-1:0]       pal_wr_idx;

  // realignment sweep after a pattern length write
  logic          sw_busy_q, sw_wr_q;
  logic [PW-1:0] sw_cnt_q, sw_k_q, sw_addr;
  logic          sw_in_len;

  assign fold_rd_addr = {match_mode_i == cfs_pkg::MODE_CASE, item_i.byte_value};

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      unique case (item_i.cmd)
        cfs_pkg::CMD_FULL_FOLD: fold_mem[{1'b0, item_i.slot}] <= item_i.byte_value;
        cfs_pkg::CMD_CASE_FOLD: fold_mem[{1'b1, item_i.slot}] <= item_i.byte_value;
        default:                fold_q <= fold_mem[fold_rd_addr];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= item_i;
    end
  end

  always_comb begin
    if (match_mode_i == cfs_pkg::MODE_FULL || match_mode_i == cfs_pkg::MODE_CASE) begin
      folded = fold_q;
    end else begin
      folded = s1_q.byte_value;
    end
  end

  assign s1_text      = s1_v_q && (s1_q.cmd == cfs_pkg::CMD_TEXT);
  assign s1_pat       = s1_v_q && (s1_q.cmd == cfs_pkg::CMD_PATTERN);
  assign pat_in_store = SW'(s1_q.slot) < SW'(MAX_PATTERN);
  assign pat_in_len   = SW'(s1_q.slot) < SW'(len_i);
  assign pal_wr_idx   = PW'(SW'(len_i) - SW'(1) - SW'(s1_q.slot));

  assign sw_in_len = LW'(sw_cnt_q) < len_i;
  assign sw_addr   = PW'(len_i - LW'(1) - LW'(sw_cnt_q));

  always_ff @(posedge clk_i) begin
    if (s1_pat && pat_in_store) begin
      pat_mem[s1_q.slot[PW-1:0]] <= folded;
    end
    if (sw_busy_q && sw_in_len) begin
      pat_rd_q <= pat_mem[sw_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_busy_q <= 1'b0;
      sw_wr_q   <= 1'b0;
      sw_cnt_q  <= '0;
      sw_k_q    <= '0;
    end else begin
      sw_wr_q <= sw_busy_q && sw_in_len;
      sw_k_q  <= sw_cnt_q;
      if (len_wr_i) begin
        sw_busy_q <= 1'b1;
        sw_cnt_q  <= '0;
      end else if (sw_busy_q) begin
        sw_cnt_q <= sw_cnt_q + PW'(1);
        if (sw_cnt_q == PW'(MAX_PATTERN - 1)) begin
          sw_busy_q <= 1'b0;
        end
      end
    end
  end

  // pal_q[k] holds the pattern byte that window tap k must equal
  always_ff @(posedge clk_i) begin
    if (sw_wr_q) begin
      pal_q[sw_k_q] <= pat_rd_q;
    end else if (s1_pat && pat_in_len) begin
      pal_q[pal_wr_idx] <= folded;
    end
  end

  always_comb begin
    win_new[0] = folded;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_text) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= win_new[k];
        eq_q[k]  <= (win_new[k] == pal_q[k]) || (LW'(k) >= len_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q.valid <= s1_text;
      step_q.eot   <= s1_q.end_of_text;
    end
  end

  assign busy_o     = sw_busy_q || sw_wr_q;
  assign s1_valid_o = s1_v_q;
  assign step_o     = step_q;
  assign eq_o       = eq_q;

endmodule

// ===== src/cfs_track.sv =====
// per-text match tracking: overlap hold, position counter, first match
module cfs_track #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [$clog2(MAX_PATTERN+1)-1:0] len_i,
  input  logic                             report_all_i,
  input  cfs_pkg::text_step_t              step_i,
  input  logic [MAX_PATTERN-1:0]           eq_i,
  output logic                             push_o,
  output cfs_pkg::res_entry_t              entry_o
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [POSITION_BITS-1:0] idx_q, start, len_p;
  logic [LW-1:0]            hold_q;
  logic                     seen_q;
  logic [31:0]              first_q, start32;
  logic                     hold_zero, cond, hit;

  assign len_p     = POSITION_BITS'(len_i);
  assign hold_zero = (hold_q == '0);
  assign cond      = hold_zero && (len_i != '0) && (idx_q >= len_p - POSITION_BITS'(1))
                     && (report_all_i || !seen_q);
  assign hit       = step_i.valid && cond && (&eq_i);
  assign start     = idx_q - (len_p - POSITION_BITS'(1));
  assign start32   = 32'(start);

  always_comb begin
    entry_o.has_match = hit;
    entry_o.match_pos = start32;
    entry_o.has_sum   = step_i.eot;
    entry_o.sum_found = seen_q || hit;
    if (seen_q) begin
      entry_o.sum_pos = first_q;
    end else if (hit) begin
      entry_o.sum_pos = start32;
    end else begin
      entry_o.sum_pos = '0;
    end
  end

  assign push_o = step_i.valid && (hit || step_i.eot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      hold_q  <= '0;
      seen_q  <= 1'b0;
      first_q <= '0;
    end else if (step_i.valid) begin
      if (step_i.eot) begin
        idx_q   <= '0;
        hold_q  <= '0;
        seen_q  <= 1'b0;
        first_q <= '0;
      end else begin
        if (!hold_zero) begin
          hold_q <= hold_q - LW'(1);
        end else if (hit) begin
          hold_q <= len_i - LW'(1);
        end
        if (hit && !seen_q) begin
          seen_q  <= 1'b1;
          first_q <= start32;
        end
        if (idx_q != '1) begin
          idx_q <= idx_q + POSITION_BITS'(1);
        end
      end
    end
  end

endmodule

// ===== src/cfs_outq.sv =====
// result queue, one entry per text byte with results, one or two transfers each
module cfs_outq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  cfs_pkg::res_entry_t          entry_i,
  output logic [cfs_pkg::OUTQ_CW-1:0]  count_o,
  cfs_result_if.source                 res_o
);

  localparam int DEPTH = cfs_pkg::OUTQ_DEPTH;
  localparam int AW    = cfs_pkg::OUTQ_AW;
  localparam int CW    = cfs_pkg::OUTQ_CW;

  cfs_pkg::res_entry_t mem_q [DEPTH];
  cfs_pkg::res_entry_t head;
  logic [AW-1:0]       wptr_q, rptr_q;
  logic [CW-1:0]       count_q;
  logic                phase_q, sum_phase, xfer, pop;

  assign head      = mem_q[rptr_q];
  assign sum_phase = phase_q || !head.has_match;

  assign res_o.valid    = (count_q != '0);
  assign res_o.kind     = sum_phase ? cfs_pkg::KIND_SUMMARY : cfs_pkg::KIND_MATCH;
  assign res_o.position = sum_phase ? head.sum_pos : head.match_pos;
  assign res_o.found    = sum_phase ? head.sum_found : 1'b1;
  assign res_o.last     = sum_phase || !head.has_sum;

  assign xfer    = res_o.valid && res_o.ready;
  assign pop     = xfer && res_o.last;
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
      phase_q <= 1'b0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + AW'(1);
      end
      if (xfer) begin
        phase_q <= !res_o.last;
      end
      count_q <= count_q + CW'(push_i) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CW'(DEPTH)) || pop)
    else $error("result queue written while full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("result queue count out of range");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && res_o.kind == cfs_pkg::KIND_SUMMARY) |-> res_o.last)
    else $error("summary transfer not marked last");

endmodule

// ===== src/case_folding_substring_search_top.sv =====
// case folding substring search, top level
// a result passes the fold lookup, compare and result queue registers before it is offered
// throughput: one item per cycle while input is not stalled; a byte with a match and a summary
//   takes two transfers on the result port, and the 4-entry result queue throttles input
// a pattern_length write stalls input while the pattern copy is realigned to the window
// reset: exact mode, empty pattern, first match only, per-text state cleared
module case_folding_substring_search_top #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cfs_item_if.sink                   item_i,
  cfs_result_if.source               result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfs_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  // wide enough for both the 7-bit register and MAX_PATTERN
  localparam int CW = (LW > 7) ? LW : 7;

  cfs_pkg::cfg_t       cfg;
  logic                len_wr;
  logic [CW-1:0]       len_cfg;
  logic [LW-1:0]       len_eff;
  cfs_pkg::item_t      item;
  logic                acc;
  logic                busy, s1_valid;
  cfs_pkg::text_step_t step;
  logic [MAX_PATTERN-1:0] eq;
  logic                push;
  cfs_pkg::res_entry_t entry;
  logic [cfs_pkg::OUTQ_CW-1:0] q_count;
  logic [cfs_pkg::OUTQ_CW:0]   q_need;

  cfs_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .len_wr_o (len_wr)
  );

  // pattern lengths above the window depth act as the full depth
  assign len_cfg = CW'(cfg.pattern_length);
  assign len_eff = (len_cfg > CW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(len_cfg);

  assign item.cmd         = cfs_pkg::cmd_e'(item_i.cmd);
  assign item.slot        = item_i.slot;
  assign item.byte_value  = item_i.byte_value;
  assign item.end_of_text = item_i.end_of_text;

  // worst case every item in flight adds one queue entry; keep room for the
  // two pipeline stages plus the item being taken now
  assign q_need = (cfs_pkg::OUTQ_CW+1)'(q_count) + (cfs_pkg::OUTQ_CW+1)'(s1_valid)
                  + (cfs_pkg::OUTQ_CW+1)'(step.valid) + (cfs_pkg::OUTQ_CW+1)'(1);
  assign item_i.ready = !busy && (q_need <= (cfs_pkg::OUTQ_CW+1)'(cfs_pkg::OUTQ_DEPTH));
  assign acc          = item_i.valid && item_i.ready;

  // fold lookup on transfer, then fold select, window shift and tap compare
  cfs_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .match_mode_i (cfg.match_mode),
    .len_i        (len_eff),
    .len_wr_i     (len_wr),
    .acc_i        (acc),
    .item_i       (item),
    .busy_o       (busy),
    .s1_valid_o   (s1_valid),
    .step_o       (step),
    .eq_o         (eq)
  );

  // reduce the tap compares, apply overlap hold and first-only rule
  cfs_track #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .len_i        (len_eff),
    .report_all_i (cfg.report_all),
    .step_i       (step),
    .eq_i         (eq),
    .push_o       (push),
    .entry_o      (entry)
  );

  // registered result queue parts the compare pipeline from the result port
  cfs_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .count_o (q_count),
    .res_o   (result_o)
  );

  a_sweep_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_wr |=> !item_i.ready)
    else $error("item taken while pattern realignment runs");

endmodule
